@@ design/ifx_pkg.sv @@
// Package for the IPv4 flow header extractor: constants, record type and
// width helpers. Depends on nothing; every design file refers to it by scoped names.
package ifx_pkg;

   // Width of the saturating byte counter
   localparam int LENGTH_BITS = 16;
   localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};
   localparam int CNT_EXT_BITS = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

   // Frame offsets
   localparam logic [LENGTH_BITS-1:0] POS_ETYPE_HI = LENGTH_BITS'(12);
   localparam logic [LENGTH_BITS-1:0] POS_ETYPE_LO = LENGTH_BITS'(13);
   localparam logic [LENGTH_BITS-1:0] POS_IHL      = LENGTH_BITS'(14);
   localparam logic [LENGTH_BITS-1:0] POS_PROTO    = LENGTH_BITS'(23);
   localparam logic [LENGTH_BITS-1:0] POS_SRC      = LENGTH_BITS'(26);
   localparam logic [LENGTH_BITS-1:0] POS_DST      = LENGTH_BITS'(30);

   // Transport header base: L2_HDR_BYTES + IHL * IHL_UNIT
   localparam logic [6:0] L2_HDR_BYTES = 7'd14;
   localparam logic [3:0] IHL_MASK     = 4'hF;
   localparam int         IHL_UNIT     = 4;
   localparam logic [6:0] FLAGS_BYTE_OFS = 7'd13;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  L4_TCP         = 8'd6;
   localparam logic [7:0]  L4_UDP         = 8'd17;

   // Record queue between front and back
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [7:0]  proto;
      logic [31:0] ports;     // source port high, destination port low
      logic [7:0]  flags;
      logic [15:0] length;
      logic [15:0] port;
      logic [7:0]  direction;
      logic [63:0] time_ms;
   } rec_type;

endpackage

@@ design/ifx_front.sv @@
// Front end of the IPv4 flow header extractor: byte counter and per-offset header capture;
// emits one raw record at an IPv4 frame's last byte if capture is enabled. Depends on ifx_pkg.
module ifx_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [7:0]            frame_byte,
   input  logic                  frame_last,
   input  logic [15:0]           port_number,
   input  logic [7:0]            flow_direction,
   input  logic [63:0]           time_ms,
   input  logic                  capture_enable,
   output logic                  rec_valid,
   output ifx_pkg::rec_type      rec
);

   logic [ifx_pkg::LENGTH_BITS-1:0] pos_ff, pos_in;
   logic [15:0] ether_ff, ether_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [31:0] ports_ff, ports_in;
   logic [7:0]  flags_ff, flags_in;
   logic [63:0] time_ff, time_in;
   logic [15:0] port_ff, port_in;
   logic [7:0]  dir_ff, dir_in;

   logic [6:0]  base;
   logic [ifx_pkg::LENGTH_BITS-1:0] pos_base;
   logic [ifx_pkg::LENGTH_BITS-1:0] cnt;
   logic [ifx_pkg::CNT_EXT_BITS-1:0] cnt_ext;
   logic        first;

   always_comb begin
      first = (pos_ff == '0);

      // clear the header captures and load time, port and direction at the first byte of a frame
      ether_in = first ? '0 : ether_ff;
      ihl_in   = first ? '0 : ihl_ff;
      proto_in = first ? '0 : proto_ff;
      src_in   = first ? '0 : src_ff;
      dst_in   = first ? '0 : dst_ff;
      ports_in = first ? '0 : ports_ff;
      flags_in = first ? '0 : flags_ff;
      time_in  = first ? time_ms : time_ff;
      port_in  = first ? port_number : port_ff;
      dir_in   = first ? flow_direction : dir_ff;

      if (pos_ff == ifx_pkg::POS_ETYPE_HI) ether_in[15:8] = frame_byte;
      if (pos_ff == ifx_pkg::POS_ETYPE_LO) ether_in[7:0]  = frame_byte;
      if (pos_ff == ifx_pkg::POS_IHL)      ihl_in = frame_byte[3:0] & ifx_pkg::IHL_MASK;
      if (pos_ff == ifx_pkg::POS_PROTO)    proto_in = frame_byte;

      case (pos_ff)
         ifx_pkg::POS_SRC:      src_in[31:24] = frame_byte;
         ifx_pkg::POS_SRC + 1:  src_in[23:16] = frame_byte;
         ifx_pkg::POS_SRC + 2:  src_in[15:8]  = frame_byte;
         ifx_pkg::POS_SRC + 3:  src_in[7:0]   = frame_byte;
         ifx_pkg::POS_DST:      dst_in[31:24] = frame_byte;
         ifx_pkg::POS_DST + 1:  dst_in[23:16] = frame_byte;
         ifx_pkg::POS_DST + 2:  dst_in[15:8]  = frame_byte;
         ifx_pkg::POS_DST + 3:  dst_in[7:0]   = frame_byte;
         default: ;
      endcase

      // transport base follows the IHL byte in the same cycle it arrives
      base     = ifx_pkg::L2_HDR_BYTES + 7'(ihl_in * ifx_pkg::IHL_UNIT);
      pos_base = ifx_pkg::LENGTH_BITS'(base);

      if (pos_ff >= pos_base && pos_ff <= pos_base + ifx_pkg::LENGTH_BITS'(3)) begin
         case (2'(pos_ff - pos_base))
            2'd0:    ports_in[31:24] = frame_byte;
            2'd1:    ports_in[23:16] = frame_byte;
            2'd2:    ports_in[15:8]  = frame_byte;
            default: ports_in[7:0]   = frame_byte;
         endcase
      end
      if (pos_ff == ifx_pkg::LENGTH_BITS'(base + ifx_pkg::FLAGS_BYTE_OFS))
         flags_in = frame_byte;

      cnt     = (pos_ff == ifx_pkg::CNT_MAX) ? pos_ff : pos_ff + 1'b1;
      cnt_ext = ifx_pkg::CNT_EXT_BITS'(cnt);
      pos_in  = frame_last ? '0 : cnt;

      rec_valid = byte_valid && frame_last && capture_enable &&
                  (ether_in == ifx_pkg::ETHERTYPE_IPV4);

      rec.source_ip = src_in;
      rec.dest_ip   = dst_in;
      rec.proto     = proto_in;
      rec.ports     = ports_in;
      rec.flags     = flags_in;
      rec.length    = (cnt_ext > ifx_pkg::CNT_EXT_BITS'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];
      rec.port      = port_in;
      rec.direction = dir_in;
      rec.time_ms   = time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (byte_valid) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_valid) begin
         ether_ff <= ether_in;
         ihl_ff   <= ihl_in;
         proto_ff <= proto_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         ports_ff <= ports_in;
         flags_ff <= flags_in;
         time_ff  <= time_in;
         port_ff  <= port_in;
         dir_ff   <= dir_in;
      end
   end

endmodule

@@ design/ifx_queue.sv @@
// Short record queue between front and back of the IPv4 flow header extractor.
// Depends on ifx_pkg for the record type and depth.
module ifx_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  ifx_pkg::rec_type wr_data,
   output logic             full,
   output logic             not_empty,
   input  logic             rd_en,
   output ifx_pkg::rec_type rd_data
);

   ifx_pkg::rec_type entry_ff [ifx_pkg::QUEUE_DEPTH];
   logic [ifx_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ifx_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ifx_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == ifx_pkg::QUEUE_CNT_BITS'(ifx_pkg::QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      rd_data   = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en)
         wr_ptr_in = (wr_ptr_ff == ifx_pkg::QUEUE_PTR_BITS'(ifx_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      if (rd_en)
         rd_ptr_in = (rd_ptr_ff == ifx_pkg::QUEUE_PTR_BITS'(ifx_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;

      count_in = count_ff;
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ design/ifx_back.sv @@
// Back end of the IPv4 flow header extractor: selects ports and flags by
// protocol and holds the result in the output register. Depends on ifx_pkg.
module ifx_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_not_empty,
   input  ifx_pkg::rec_type q_data,
   output logic             q_take,
   output logic             out_empty,
   input  logic             out_pop,
   output logic [31:0]      source_address,
   output logic [31:0]      dest_address,
   output logic [7:0]       ip_protocol,
   output logic [15:0]      source_port,
   output logic [15:0]      dest_port,
   output logic [7:0]       tcp_flag_bits,
   output logic [15:0]      frame_length,
   output logic [15:0]      rec_port,
   output logic [7:0]       rec_direction,
   output logic [63:0]      rec_time_ms
);

   logic        valid_ff, valid_in;
   logic [31:0] ports_sel;
   logic [7:0]  flags_sel;
   ifx_pkg::rec_type out_ff, out_in;

   always_comb begin
      q_take   = q_not_empty && (!valid_ff || out_pop);
      valid_in = q_take || (valid_ff && !out_pop);

      // zero ports unless TCP or UDP; flags only for TCP
      ports_sel = '0;
      flags_sel = '0;
      case (q_data.proto)
         ifx_pkg::L4_TCP: begin
            ports_sel = q_data.ports;
            flags_sel = q_data.flags;
         end
         ifx_pkg::L4_UDP: begin
            ports_sel = q_data.ports;
         end
         default: ;
      endcase

      out_in       = q_data;
      out_in.ports = ports_sel;
      out_in.flags = flags_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_take) begin
         out_ff <= out_in;
      end
   end

   assign out_empty      = !valid_ff;
   assign source_address = out_ff.source_ip;
   assign dest_address   = out_ff.dest_ip;
   assign ip_protocol    = out_ff.proto;
   assign source_port    = out_ff.ports[31:16];
   assign dest_port      = out_ff.ports[15:0];
   assign tcp_flag_bits  = out_ff.flags;
   assign frame_length   = out_ff.length;
   assign rec_port       = out_ff.port;
   assign rec_direction  = out_ff.direction;
   assign rec_time_ms    = out_ff.time_ms;

endmodule

@@ design/ipv4_flow_header_extractor_core.sv @@
// Top level of the IPv4 flow header extractor: byte parser front end, record
// queue and output back end. Depends on ifx_pkg, ifx_front, ifx_queue, ifx_back.
//
//   channel | direction | handshake              | transaction
//   --------+-----------+------------------------+---------------------------------
//   req_    | in        | push / full            | one frame byte plus side data
//   rsp_    | out       | empty / pop            | one flow record per IPv4 frame
//   csr_    | in        | valid / ready          | capture_enable write
//
// One byte per cycle while req_full is low: the front end captures each header byte
// at its offset in the cycle it arrives, so a byte can follow every cycle. A record
// reaches the rsp_ side through the queue, then the output register.
// req_full rises only when the two-entry record queue is full; the output
// register keeps draining it independently of the input side.
// Reset (synchronous, active high) empties queue and output and sets
// capture_enable to 1. csr_ready is always high.
module ipv4_flow_header_extractor_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_last,
   input  logic [15:0] req_port_number,
   input  logic [7:0]  req_flow_direction,
   input  logic [63:0] req_time_ms,

   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_source_address,
   output logic [31:0] rsp_dest_address,
   output logic [7:0]  rsp_ip_protocol,
   output logic [15:0] rsp_source_port,
   output logic [15:0] rsp_dest_port,
   output logic [7:0]  rsp_tcp_flag_bits,
   output logic [15:0] rsp_frame_length,
   output logic [15:0] rsp_rec_port,
   output logic [7:0]  rsp_rec_direction,
   output logic [63:0] rsp_rec_time_ms,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_capture_enable
);

   logic             capture_enable_ff;
   logic             byte_valid;
   logic             rec_valid;
   ifx_pkg::rec_type rec;
   logic             q_full;
   logic             q_not_empty;
   logic             q_take;
   ifx_pkg::rec_type q_data;

   // Always ready; the user must write only while the block is idle (not enforced).
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capture_enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         capture_enable_ff <= csr_capture_enable;
      end
   end

   // Hold off new bytes only while the queue has no room for a record.
   assign req_full   = q_full;
   assign byte_valid = req_push && !q_full;

   ifx_front u_front (
      .clock          (clock),
      .reset          (reset),
      .byte_valid     (byte_valid),
      .frame_byte     (req_frame_byte),
      .frame_last     (req_frame_last),
      .port_number    (req_port_number),
      .flow_direction (req_flow_direction),
      .time_ms        (req_time_ms),
      .capture_enable (capture_enable_ff),
      .rec_valid      (rec_valid),
      .rec            (rec)
   );

   // Decouple parsing from result delivery.
   ifx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (rec_valid),
      .wr_data   (rec),
      .full      (q_full),
      .not_empty (q_not_empty),
      .rd_en     (q_take),
      .rd_data   (q_data)
   );

   ifx_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_data         (q_data),
      .q_take         (q_take),
      .out_empty      (rsp_empty),
      .out_pop        (rsp_pop),
      .source_address (rsp_source_address),
      .dest_address   (rsp_dest_address),
      .ip_protocol    (rsp_ip_protocol),
      .source_port    (rsp_source_port),
      .dest_port      (rsp_dest_port),
      .tcp_flag_bits  (rsp_tcp_flag_bits),
      .frame_length   (rsp_frame_length),
      .rec_port       (rsp_rec_port),
      .rec_direction  (rsp_rec_direction),
      .rec_time_ms    (rsp_rec_time_ms)
   );

endmodule
